// ----- rtl/core/bf2d_pkg.sv -----
// Shared types and constants for the zero-padded 2-D box filter.
// Used by bf2d_ctrl, bf2d_dp and box_filter_2d_zero_pad; depends on nothing.
`default_nettype none

package bf2d_pkg;

    localparam int PIX_W      = 8;
    localparam int PORT_CH    = 4;
    localparam int COORD_W    = 11;
    localparam int Q_W        = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int KSZ_W      = 3;
    localparam int DIM_W      = 12;
    localparam int CHN_W      = 3;

    localparam int DEF_MAX_KERNEL   = 7;
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 2048;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam logic [KSZ_W-1:0] RST_KERNEL   = 3'd3;
    localparam logic [DIM_W-1:0] RST_WIDTH    = 12'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT   = 12'd480;
    localparam logic [CHN_W-1:0] RST_CHANNELS = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL   = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2,
        CFG_CHANNELS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic take;
        logic gath;
        logic dload;
        logic div;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic gath_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/bf2d_ctrl.sv -----
// Sequencer of the box filter: one item at a time through gather, divide and output.
// Depends on bf2d_pkg for the command and status structs.
`default_nettype none

module bf2d_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire bf2d_pkg::t_sts i_sts,
    output bf2d_pkg::t_cmd     o_cmd,
    output logic               o_stall
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_GATH  = 6'b000010,
        ST_FLUSH = 6'b000100,
        ST_DLOAD = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.take     = (r_state == ST_IDLE) && i_valid;
        o_cmd.gath     = (r_state == ST_GATH);
        o_cmd.dload    = (r_state == ST_DLOAD);
        o_cmd.div      = (r_state == ST_DIV);
        o_cmd.load_out = (r_state == ST_OUT) && i_sts.out_free;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_sts.has_result) n_state = ST_GATH;
            end
            ST_GATH: begin
                if (i_sts.gath_last) n_state = ST_FLUSH;
            end
            ST_FLUSH: n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/bf2d_dp.sv -----
// Datapath of the box filter: settings, position counters, line store, window
// accumulation, per-channel restoring dividers and the output register. Uses bf2d_pkg.
`default_nettype none

module bf2d_dp #(
    parameter int MAX_KERNEL   = bf2d_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH    = bf2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bf2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bf2d_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bf2d_pkg::t_cmd                    i_cmd,
    output bf2d_pkg::t_sts                         o_sts,
    input  wire logic                              i_cfg_we,
    input  wire logic [bf2d_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bf2d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_action,
    input  wire logic [bf2d_pkg::PIX_W-1:0]        i_pix [bf2d_pkg::PORT_CH],
    input  wire logic                              i_stall,
    output logic                                   o_valid,
    output logic [bf2d_pkg::Q_W-1:0]               o_chan [bf2d_pkg::PORT_CH],
    output logic [bf2d_pkg::COORD_W-1:0]           o_row,
    output logic [bf2d_pkg::COORD_W-1:0]           o_col,
    output logic                                   o_frame_done
);

    localparam int PW    = bf2d_pkg::PIX_W;
    localparam int QW    = bf2d_pkg::Q_W;
    localparam int S     = MAX_KERNEL + 1;
    localparam int SW    = (S > 1) ? $clog2(S) : 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
    localparam int KW    = $clog2(MAX_KERNEL + 1);
    localparam int LW    = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_KERNEL) + 1);
    localparam int AW    = $clog2(MAX_KERNEL * MAX_KERNEL * (2**PW - 1) + 1);
    localparam int DW    = $clog2(MAX_KERNEL * MAX_KERNEL * (2**PW) + 1);
    localparam int CHW   = $clog2(MAX_CHANNELS + 1);
    localparam int MW    = MAX_CHANNELS * PW;
    localparam int ADW   = SW + CW;
    localparam int DEPTH = S * (2**CW);
    localparam int KTW   = (bf2d_pkg::KSZ_W > KW) ? bf2d_pkg::KSZ_W : KW;
    localparam int WTW   = (bf2d_pkg::DIM_W > WW) ? bf2d_pkg::DIM_W : WW;
    localparam int HTW   = (bf2d_pkg::DIM_W > HW) ? bf2d_pkg::DIM_W : HW;
    localparam int CTW   = (bf2d_pkg::CHN_W > CHW) ? bf2d_pkg::CHN_W : CHW;
    localparam int NW    = $clog2(QW);

    // Settings as written.
    logic [bf2d_pkg::KSZ_W-1:0] r_ksz;
    logic [bf2d_pkg::DIM_W-1:0] r_wid;
    logic [bf2d_pkg::DIM_W-1:0] r_hgt;
    logic [bf2d_pkg::CHN_W-1:0] r_chn;

    // Effective settings after clamping.
    logic [KW-1:0]   k_eff;
    logic [KW-1:0]   p_eff;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [CHW-1:0]  nch;
    logic [2*KW-1:0] kk;
    logic [KTW-1:0]  kt;
    logic [WTW-1:0]  wt;
    logic [HTW-1:0]  ht;
    logic [CTW-1:0]  ct;

    always_comb begin
        kt = KTW'(r_ksz);
        if (kt == '0) kt = KTW'(1);
        if (kt > KTW'(MAX_KERNEL)) kt = KTW'(MAX_KERNEL);
        if (!kt[0]) kt = kt - KTW'(1);
        if (kt == '0) kt = KTW'(1);
        k_eff = kt[KW-1:0];
        p_eff = k_eff >> 1;
        kk    = {{KW{1'b0}}, k_eff} * {{KW{1'b0}}, k_eff};

        wt = WTW'(r_wid);
        if (wt == '0) wt = WTW'(1);
        if (wt > WTW'(MAX_WIDTH)) wt = WTW'(MAX_WIDTH);
        w_eff = wt[WW-1:0];

        ht = HTW'(r_hgt);
        if (ht == '0) ht = HTW'(1);
        if (ht > HTW'(MAX_HEIGHT)) ht = HTW'(MAX_HEIGHT);
        h_eff = ht[HW-1:0];

        ct = CTW'(r_chn);
        if (ct == '0) ct = CTW'(1);
        if (ct > CTW'(MAX_CHANNELS)) ct = CTW'(MAX_CHANNELS);
        nch = ct[CHW-1:0];
    end

    // Position counters.
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [SW-1:0] r_in_slot;
    logic [LW-1:0] r_lin;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;
    logic [SW-1:0] r_out_slot;

    // Window sequencing.
    logic [KW-1:0] r_dr;
    logic [KW-1:0] r_dc;
    logic [SW-1:0] r_rslot;

    // Output register.
    logic                         r_oval;
    logic [QW-1:0]                r_och [bf2d_pkg::PORT_CH];
    logic [bf2d_pkg::COORD_W-1:0] r_orow;
    logic [bf2d_pkg::COORD_W-1:0] r_ocol;
    logic                         r_odone;

    logic              ignore;
    logic              wr_en;
    logic [KW+WW-1:0]  pw;
    logic [LW-1:0]     lag;
    logic [WW-1:0]     in_col_inc;
    logic [WW-1:0]     out_col_inc;
    logic [SW:0]       start_slot;
    logic [RW:0]       rsum;
    logic [WW:0]       csum;
    logic              rd_ok;
    logic [WW:0]       cc;
    logic              done;
    logic              restart;
    logic [MW-1:0]     wdata;

    always_comb begin
        ignore  = i_action && (r_in_row == '0) && (r_in_col == '0);
        wr_en   = i_cmd.take && !ignore && (r_in_row < RW'(h_eff));
        pw      = {{WW{1'b0}}, p_eff} * {{KW{1'b0}}, w_eff};
        lag     = LW'(pw) + LW'(p_eff);
        in_col_inc  = WW'(r_in_col) + WW'(1);
        out_col_inc = WW'(r_out_col) + WW'(1);

        // First line-store row of the window, taken modulo the row count.
        start_slot = (SW+1)'(r_out_slot) + (SW+1)'(S) - (SW+1)'(p_eff);
        if (start_slot >= (SW+1)'(S)) start_slot = start_slot - (SW+1)'(S);

        rsum  = (RW+1)'(r_out_row) + (RW+1)'(r_dr);
        csum  = (WW+1)'(r_out_col) + (WW+1)'(r_dc);
        cc    = csum - (WW+1)'(p_eff);
        rd_ok = (rsum >= (RW+1)'(p_eff))
             && ((rsum - (RW+1)'(p_eff)) < (RW+1)'(h_eff))
             && (csum >= (WW+1)'(p_eff))
             && (cc < (WW+1)'(w_eff));

        done    = (r_out_row == (RW'(h_eff) - RW'(1)))
               && (WW'(r_out_col) == (w_eff - WW'(1)));
        restart = (i_cfg_we) || (i_cmd.load_out && done);

        wdata = '0;
        for (int g = 0; g < MAX_CHANNELS; g++) begin
            wdata[g*PW +: PW] = i_action ? '0 : i_pix[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksz <= bf2d_pkg::RST_KERNEL;
            r_wid <= bf2d_pkg::RST_WIDTH;
            r_hgt <= bf2d_pkg::RST_HEIGHT;
            r_chn <= bf2d_pkg::RST_CHANNELS;
        end else if (i_cfg_we) begin
            case (bf2d_pkg::t_cfg_idx'(i_cfg_idx))
                bf2d_pkg::CFG_KERNEL:   r_ksz <= i_cfg_data[bf2d_pkg::KSZ_W-1:0];
                bf2d_pkg::CFG_WIDTH:    r_wid <= i_cfg_data[bf2d_pkg::DIM_W-1:0];
                bf2d_pkg::CFG_HEIGHT:   r_hgt <= i_cfg_data[bf2d_pkg::DIM_W-1:0];
                bf2d_pkg::CFG_CHANNELS: r_chn <= i_cfg_data[bf2d_pkg::CHN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_lin      <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
        end else begin
            if (i_cmd.take && !ignore) begin
                r_lin <= r_lin + LW'(1);
                if (in_col_inc >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                    r_in_slot <= (r_in_slot == SW'(S - 1)) ? '0 : r_in_slot + SW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                if (out_col_inc >= w_eff) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                    r_out_slot <= (r_out_slot == SW'(S - 1)) ? '0 : r_out_slot + SW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dr    <= '0;
            r_dc    <= '0;
            r_rslot <= start_slot[SW-1:0];
        end else if (i_cmd.gath) begin
            if (r_dc == k_eff - KW'(1)) begin
                r_dc    <= '0;
                r_dr    <= r_dr + KW'(1);
                r_rslot <= (r_rslot == SW'(S - 1)) ? '0 : r_rslot + SW'(1);
            end else begin
                r_dc <= r_dc + KW'(1);
            end
        end
    end

    // Line store: written on the take cycle, read one window word a cycle.
    logic [MW-1:0]  mem [DEPTH];
    logic [MW-1:0]  r_mem_q;
    logic [ADW-1:0] wr_addr;
    logic [ADW-1:0] rd_addr;

    assign wr_addr = {r_in_slot, r_in_col};
    assign rd_addr = {r_rslot, cc[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wdata;
        r_mem_q <= mem[rd_addr];
    end

    logic r_acc_en;
    logic r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.gath;
        end
        r_rd_ok <= rd_ok;
    end

    // Shared divisor and step count for the per-channel dividers.
    logic [DW-1:0] r_dvs;
    logic [NW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.dload) begin
            r_dvs <= DW'(kk) << (QW - 1);
            r_cnt <= NW'(QW - 1);
        end else if (i_cmd.div) begin
            r_dvs <= r_dvs >> 1;
            r_cnt <= r_cnt - NW'(1);
        end
    end

    logic [QW-1:0] q_arr [bf2d_pkg::PORT_CH];

    for (genvar g = 0; g < bf2d_pkg::PORT_CH; g++) begin : g_lane
        if (g < MAX_CHANNELS) begin : g_on
            logic [AW-1:0] r_acc;
            logic [DW-1:0] r_rem;
            logic [QW-1:0] r_q;

            always_ff @(posedge i_clk) begin
                if (i_cmd.take) begin
                    r_acc <= '0;
                end else if (r_acc_en && r_rd_ok) begin
                    r_acc <= r_acc + AW'(r_mem_q[g*PW +: PW]);
                end
                // Rounding is exact: half the divisor is added before the division.
                if (i_cmd.dload) begin
                    r_rem <= DW'(r_acc) + DW'(kk >> 1);
                    r_q   <= '0;
                end else if (i_cmd.div) begin
                    if (r_rem >= r_dvs) begin
                        r_rem <= r_rem - r_dvs;
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                end
            end

            assign q_arr[g] = r_q;
        end else begin : g_off
            assign q_arr[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
        if (i_cmd.load_out) begin
            for (int g = 0; g < bf2d_pkg::PORT_CH; g++) begin
                r_och[g] <= (CHW'(g) < nch) ? q_arr[g] : '0;
            end
            r_orow  <= bf2d_pkg::COORD_W'(r_out_row);
            r_ocol  <= bf2d_pkg::COORD_W'(r_out_col);
            r_odone <= done;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.has_result = !ignore && (r_lin >= lag);
        o_sts.gath_last  = (r_dr == k_eff - KW'(1)) && (r_dc == k_eff - KW'(1));
        o_sts.div_last   = (r_cnt == '0);
        o_sts.out_free   = !r_oval || !i_stall;
    end

    assign o_valid      = r_oval;
    assign o_chan       = r_och;
    assign o_row        = r_orow;
    assign o_col        = r_ocol;
    assign o_frame_done = r_odone;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_oval || !i_stall))
        else $error("output word overwritten while stalled");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_oval)
        else $error("loaded word not presented");

    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gath |-> (r_dr < k_eff && r_dc < k_eff))
        else $error("window index outside the kernel");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/box_filter_2d_zero_pad.sv -----
// Box filter over a zero-padded frame, up to four 8-bit channels per pixel.
//
// Input channel: i_valid / o_stall with i_action and i_in_chan0..3. A word is
// taken when i_valid is high and o_stall low. Action 0 is a frame pixel in
// raster order, action 1 a drain word that pushes the last rows and columns out.
// Output channel: o_valid / i_stall with the rounded window means, the frame
// position and o_frame_done on the last pixel of the frame.
// Settings go through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them
// only while idle, which the block does not enforce; any write restarts the frame.
// A word that yields no result leaves the block idle; one that does keeps it busy
// while the window is read one word a cycle from the line store (one write and
// one read port) and an 8-step restoring divider per channel forms the mean.
// The finished result sits in an output register, so the next word is taken while
// it waits; a stalled receiver holds back the following result, and the input
// with it.
// Reset clears the settings to their defaults and all position counters; the line
// store is not cleared.
`default_nettype none

module box_filter_2d_zero_pad #(
    parameter int MAX_KERNEL   = bf2d_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH    = bf2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bf2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bf2d_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bf2d_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bf2d_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_action,
    input  wire logic [bf2d_pkg::PIX_W-1:0]      i_in_chan0,
    input  wire logic [bf2d_pkg::PIX_W-1:0]      i_in_chan1,
    input  wire logic [bf2d_pkg::PIX_W-1:0]      i_in_chan2,
    input  wire logic [bf2d_pkg::PIX_W-1:0]      i_in_chan3,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [bf2d_pkg::Q_W-1:0]             o_out_chan0,
    output logic [bf2d_pkg::Q_W-1:0]             o_out_chan1,
    output logic [bf2d_pkg::Q_W-1:0]             o_out_chan2,
    output logic [bf2d_pkg::Q_W-1:0]             o_out_chan3,
    output logic [bf2d_pkg::COORD_W-1:0]         o_out_row,
    output logic [bf2d_pkg::COORD_W-1:0]         o_out_col,
    output logic                                 o_frame_done
);

    bf2d_pkg::t_cmd cmd;
    bf2d_pkg::t_sts sts;

    logic [bf2d_pkg::PIX_W-1:0] in_pix  [bf2d_pkg::PORT_CH];
    logic [bf2d_pkg::Q_W-1:0]   out_pix [bf2d_pkg::PORT_CH];

    assign in_pix[0] = i_in_chan0;
    assign in_pix[1] = i_in_chan1;
    assign in_pix[2] = i_in_chan2;
    assign in_pix[3] = i_in_chan3;

    bf2d_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    bf2d_dp #(
        .MAX_KERNEL   (MAX_KERNEL),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_pix        (in_pix),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_chan       (out_pix),
        .o_row        (o_out_row),
        .o_col        (o_out_col),
        .o_frame_done (o_frame_done)
    );

    assign o_out_chan0 = out_pix[0];
    assign o_out_chan1 = out_pix[1];
    assign o_out_chan2 = out_pix[2];
    assign o_out_chan3 = out_pix[3];

endmodule

`default_nettype wire

// ----- tb/tb_box_filter_2d_zero_pad.sv -----
// Self-checking testbench for box_filter_2d_zero_pad: random and directed frames
// with random idling on both channels, checked against a built-in window-mean predictor.
// Depends on bf2d_pkg and the box_filter_2d_zero_pad RTL.
`timescale 1ns / 100ps

module tb_box_filter_2d_zero_pad;

    localparam int STORE_ROWS = bf2d_pkg::DEF_MAX_KERNEL + 1;
    localparam int WATCHDOG   = 3000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic            drain;
        logic [3:0][7:0] smp;
    } t_pixel;

    typedef struct packed {
        logic [3:0][7:0] mean;
        logic [10:0]     row;
        logic [10:0]     col;
        logic            done;
    } t_blur;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_idx;
    logic [11:0]     i_cfg_data;
    logic            i_valid;
    logic            o_stall;
    logic            i_action;
    logic [7:0]      i_in_chan0, i_in_chan1, i_in_chan2, i_in_chan3;
    logic            o_valid;
    logic            i_stall;
    logic [7:0]      o_out_chan0, o_out_chan1, o_out_chan2, o_out_chan3;
    logic [10:0]     o_out_row, o_out_col;
    logic            o_frame_done;

    box_filter_2d_zero_pad uut (.*);

    // Predictor state.
    logic [31:0] line_mem [0:STORE_ROWS*bf2d_pkg::DEF_MAX_WIDTH-1];
    int unsigned in_row, in_col, out_row, out_col;
    logic [2:0]  reg_kernel;
    logic [11:0] reg_width, reg_height;
    logic [2:0]  reg_chans;

    t_pixel pending_pix[$];
    t_blur  expected_means[$];

    int  n_errors, n_pixels, n_means, n_frames, idle_cycles;
    bit  word_taken, mean_taken, hold_req, no_idle;
    int  tx_gap, rx_wait, rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_dim(input logic [11:0] v);
        if (v == 0) return 1;
        return (v > bf2d_pkg::DEF_MAX_WIDTH) ? bf2d_pkg::DEF_MAX_WIDTH : v;
    endfunction

    function automatic int unsigned eff_k(input logic [2:0] v);
        int unsigned kv;
        kv = (v == 0) ? 1 : v;
        if (kv[0] == 1'b0) kv = kv - 1;
        return kv;
    endfunction

    function automatic int unsigned eff_ch(input logic [2:0] v);
        if (v == 0) return 1;
        return (v > bf2d_pkg::DEF_MAX_CHANNELS) ? bf2d_pkg::DEF_MAX_CHANNELS : v;
    endfunction

    // Advances the predictor by one word; returns 1 when a mean pixel is due.
    function automatic bit blur_step(input t_pixel px, output t_blur res);
        int unsigned w, h, k, p, nch, idx, lag, rr, cc, kk;
        int unsigned sums [4];
        logic [31:0] word;
        w   = eff_dim(reg_width);
        h   = eff_dim(reg_height);
        k   = eff_k(reg_kernel);
        p   = k / 2;
        nch = eff_ch(reg_chans);
        res = '0;
        if (px.drain && in_row == 0 && in_col == 0) return 1'b0;
        if (in_row < h)
            line_mem[(in_row % STORE_ROWS) * bf2d_pkg::DEF_MAX_WIDTH + in_col] =
                px.drain ? '0 : px.smp;
        idx = in_row * w + in_col;
        lag = p * w + p;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (idx < lag) return 1'b0;
        for (int c = 0; c < 4; c++) sums[c] = 0;
        for (int dr = 0; dr < k; dr++) begin
            for (int dc = 0; dc < k; dc++) begin
                word = '0;
                if (out_row + dr >= p && out_col + dc >= p) begin
                    rr = out_row + dr - p;
                    cc = out_col + dc - p;
                    if (rr < h && cc < w)
                        word = line_mem[(rr % STORE_ROWS) * bf2d_pkg::DEF_MAX_WIDTH + cc];
                end
                for (int c = 0; c < 4; c++) sums[c] += word[8*c +: 8];
            end
        end
        kk = k * k;
        for (int c = 0; c < 4; c++)
            res.mean[c] = (c < nch) ? 8'((sums[c] + kk / 2) / kk) : 8'd0;
        res.row  = out_row[10:0];
        res.col  = out_col[10:0];
        res.done = (out_row == h - 1) && (out_col == w - 1);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (res.done) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end
        return 1'b1;
    endfunction

    // Predictor update, result checking and watchdog, all on the rising edge.
    always @(posedge i_clk) begin : check_proc
        t_blur got, want;
        t_pixel px;
        if (!i_rst_n) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            reg_kernel = bf2d_pkg::RST_KERNEL; reg_width = bf2d_pkg::RST_WIDTH;
            reg_height = bf2d_pkg::RST_HEIGHT; reg_chans = bf2d_pkg::RST_CHANNELS;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (i_cfg_we) begin
                case (bf2d_pkg::t_cfg_idx'(i_cfg_idx))
                    bf2d_pkg::CFG_KERNEL:   reg_kernel = i_cfg_data[2:0];
                    bf2d_pkg::CFG_WIDTH:    reg_width  = i_cfg_data;
                    bf2d_pkg::CFG_HEIGHT:   reg_height = i_cfg_data;
                    bf2d_pkg::CFG_CHANNELS: reg_chans  = i_cfg_data[2:0];
                    default: ;
                endcase
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
                idle_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                idle_cycles = 0;
                mean_taken = 1'b1;
                got = '{mean: {o_out_chan3, o_out_chan2, o_out_chan1, o_out_chan0},
                        row: o_out_row, col: o_out_col, done: o_frame_done};
                if (expected_means.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected word, expected none, actual %p", $time, got);
                end else begin
                    want = expected_means.pop_front();
                    n_means++;
                    if (got.done) n_frames++;
                    if (got !== want) begin
                        n_errors++;
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                idle_cycles = 0;
                word_taken = 1'b1;
                px = '{drain: i_action, smp: {i_in_chan3, i_in_chan2, i_in_chan1, i_in_chan0}};
                if (!(px.drain && in_row == 0 && in_col == 0)) n_pixels++;
                if (blur_step(px, want)) expected_means.push_back(want);
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: timeout, %0d words still expected", $time, expected_means.size());
                $display("[box_filter_2d_zero_pad] ERROR");
                $finish;
            end
        end
    end

    // Sender: one word at a time from the pending queue, with random gaps.
    always @(negedge i_clk) begin : send_proc
        bit holding;
        t_pixel px;
        holding = i_valid;
        if (word_taken) begin
            holding = 1'b0;
            word_taken = 1'b0;
            tx_gap = no_idle ? 0 : $urandom_range(0, 7);
        end
        if (!holding && i_rst_n) begin
            if (tx_gap > 0) tx_gap--;
            else if (pending_pix.size() > 0) begin
                px = pending_pix.pop_front();
                holding = 1'b1;
                i_action   <= px.drain;
                i_in_chan0 <= px.smp[0];
                i_in_chan1 <= px.smp[1];
                i_in_chan2 <= px.smp[2];
                i_in_chan3 <= px.smp[3];
            end
        end
        i_valid <= holding;
    end

    // Receiver: random stalls per word, plus one long hold-off on request.
    always @(negedge i_clk) begin : recv_proc
        if (hold_req) begin
            hold_req = 1'b0;
            rx_hold = HOLD_LEN;
        end
        if (mean_taken) begin
            mean_taken = 1'b0;
            rx_wait = no_idle ? 0 : $urandom_range(0, 7);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(input bf2d_pkg::t_cfg_idx idx, input logic [11:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pixel rand_pixel(input bit drain);
        t_pixel px;
        int sel;
        sel = $urandom_range(0, 7);
        px.drain = drain;
        for (int c = 0; c < 4; c++)
            px.smp[c] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        return px;
    endfunction

    // Sets up one frame, sends it and its drain words, and waits until it has left.
    task automatic send_frame(input logic [2:0] k, input logic [11:0] w, input logic [11:0] h,
                              input logic [2:0] ch, input bit noisy);
        int unsigned npix, lag, ke;
        write_reg(bf2d_pkg::CFG_KERNEL, {9'($urandom_range(0, 511)), k});
        write_reg(bf2d_pkg::CFG_WIDTH, w);
        write_reg(bf2d_pkg::CFG_HEIGHT, h);
        write_reg(bf2d_pkg::CFG_CHANNELS, {9'($urandom_range(0, 511)), ch});
        npix = eff_dim(w) * eff_dim(h);
        ke   = eff_k(k);
        lag  = (ke / 2) * eff_dim(w) + ke / 2;
        // A drain word before the first pixel is ignored.
        if (noisy && $urandom_range(0, 1)) pending_pix.push_back(rand_pixel(1'b1));
        for (int unsigned i = 0; i < npix; i++)
            pending_pix.push_back(rand_pixel(noisy && $urandom_range(0, 15) == 0));
        // Past the last row a pixel behaves exactly like a drain word.
        for (int unsigned i = 0; i < lag; i++)
            pending_pix.push_back(rand_pixel(!(noisy && $urandom_range(0, 3) == 0)));
        while (pending_pix.size() > 0 || i_valid || expected_means.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_action = 1'b0; i_stall = 1'b0;
        i_in_chan0 = '0; i_in_chan1 = '0; i_in_chan2 = '0; i_in_chan3 = '0;
        n_errors = 0; n_pixels = 0; n_means = 0; n_frames = 0;
        word_taken = 0; mean_taken = 0; hold_req = 0; no_idle = 0;
        tx_gap = 0; rx_wait = 0; rx_hold = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames: padding everywhere, odd and even kernels, odd channel counts.
        send_frame(3'd3, 12'd4, 12'd3, 3'd4, 1'b1);
        send_frame(3'd7, 12'd1, 12'd1, 3'd0, 1'b0);
        send_frame(3'd0, 12'd2, 12'd0, 3'd7, 1'b1);
        send_frame(3'd6, 12'd3, 12'd2, 3'd5, 1'b0);

        // The receiver holds off while the sender keeps offering words.
        hold_req = 1'b1;
        send_frame(3'd3, 12'd8, 12'd6, 3'd4, 1'b0);

        // Largest kernel over enough rows to wrap the line store.
        send_frame(3'd7, 12'd20, 12'd9, 3'd4, 1'b0);

        while (n_pixels < 500) begin
            no_idle = ($urandom_range(0, 4) == 0);
            send_frame(3'($urandom_range(0, 7)), 12'($urandom_range(1, 10)),
                       12'($urandom_range(1, 6)), 3'($urandom_range(0, 7)),
                       $urandom_range(0, 2) == 0);
        end
        no_idle = 1'b0;

        repeat (100) @(posedge i_clk);
        $display("Covered %0d pixel and drain words, %0d mean pixels over %0d frames.",
                 n_pixels, n_means, n_frames);
        $display("Kernels 1 to 7, clamped settings, line store wrap, long receiver hold-off.");
        if (n_errors == 0 && expected_means.size() == 0)
            $display("[box_filter_2d_zero_pad] OK");
        else
            $display("[box_filter_2d_zero_pad] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bf2d_pkg.sv
rtl/core/bf2d_ctrl.sv
rtl/core/bf2d_dp.sv
rtl/core/box_filter_2d_zero_pad.sv
tb/tb_box_filter_2d_zero_pad.sv
